>>> hw/rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared types and codes for the checked integer ALU
// Request/response structs, operation and status codes, controller commands.
// ----------------------------------------------------------------------------
package cia_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5,
    OP_NEG = 3'd6,
    OP_CMP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_NEGEX = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_POW,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic decode;   // resolve non-iterative ops, set up iterative work
    logic mul_step;
    logic div_step;
    logic pow_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic need_pow;
    logic iter_last; // current iterative op finishes on this step
  } sts_t;

endpackage

>>> hw/rtl/cia_datapath.sv
// ----------------------------------------------------------------------------
// cia_datapath: operand registers, shift-add multiplier, restoring divider
// One bit per cycle for multiply and divide. Power runs square-and-multiply
// with each multiply done by the same serial unit.
// ----------------------------------------------------------------------------
module cia_datapath #(
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cia_pkg::req_t req_i,
  input  cia_pkg::cmd_t cmd_i,
  output cia_pkg::sts_t sts_o,
  output cia_pkg::rsp_t rsp_o
);

  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] LastBit = CW'(DW - 1);

  logic [2:0]    op_q;
  logic [DW-1:0] a_q, b_q;
  logic [63:0]   res_q, res_d;
  logic [1:0]    st_q, st_d;

  // multiplier: magnitudes, product accumulates into a 2*DW register
  logic [DW-1:0]   my_q, my_d;     // multiplier magnitude (shifted right)
  logic [2*DW-1:0] mp_q, mp_d;
  logic [2*DW-1:0] mxs_q, mxs_d;   // shifted multiplicand
  logic            mneg_q, mneg_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  // divider
  logic [DW-1:0] dq_q, dq_d;       // dividend shifting into quotient
  logic [DW:0]   dr_q, dr_d;       // partial remainder
  logic [DW-1:0] dd_q, dd_d;       // divisor magnitude
  logic          qneg_q, qneg_d, rneg_q, rneg_d;

  // power: base, acc, exponent, phase
  logic [DW-1:0] pbase_q, pbase_d, pacc_q, pacc_d;
  logic [DW-1:0] pexp_q, pexp_d;
  logic          pphase_q, pphase_d; // 0: acc*=base, 1: base*=base
  logic          pbase_ovf_q, pbase_ovf_d;
  logic          mul_fresh_q, mul_fresh_d;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    mag = x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [63:0] sx(input logic [DW-1:0] x);
    sx = 64'(signed'(x));
  endfunction

  logic [DW-1:0] a_in, b_in, minv, sum, diff, neg_a;
  logic          add_ovf, sub_ovf;
  logic [2*DW-1:0] limit;
  logic          mul_ovf;
  logic [DW-1:0] mul_res;
  logic [DW:0]   dr_sh;
  logic          dfit;
  logic [2*DW-1:0] mp_next;
  logic [DW-1:0] mx_op, my_op;
  logic          mneg_op;

  assign a_in  = req_i.operand_a[DW-1:0];
  assign b_in  = req_i.operand_b[DW-1:0];
  assign minv  = {1'b1, {(DW-1){1'b0}}};
  assign sum   = a_q + b_q;
  assign diff  = a_q - b_q;
  assign neg_a = ~a_q + 1'b1;
  assign add_ovf = ~(a_q[DW-1] ^ b_q[DW-1]) & (a_q[DW-1] ^ sum[DW-1]);
  assign sub_ovf = (a_q[DW-1] ^ b_q[DW-1]) & (a_q[DW-1] ^ diff[DW-1]);

  // product check against the signed limit
  assign mp_next = my_q[0] ? mp_q + mxs_q : mp_q;
  assign limit   = mneg_q ? (2*DW)'(minv) : (2*DW)'(minv - 1'b1);
  assign mul_ovf = mp_next > limit;
  assign mul_res = mneg_q ? (~mp_next[DW-1:0] + 1'b1) : mp_next[DW-1:0];

  assign dr_sh = {dr_q[DW-1:0], dq_q[DW-1]};
  assign dfit  = dr_sh >= {1'b0, dd_q};

  // next multiply operands for power
  always_comb begin
    if (!pphase_q) begin
      mx_op   = mag(pacc_q);
      my_op   = mag(pbase_q);
      mneg_op = pacc_q[DW-1] ^ pbase_q[DW-1];
    end else begin
      mx_op   = mag(pbase_q);
      my_op   = mag(pbase_q);
      mneg_op = 1'b0;
    end
  end

  always_comb begin
    res_d = res_q; st_d = st_q;
    my_d = my_q; mp_d = mp_q; mxs_d = mxs_q; mneg_d = mneg_q;
    cnt_d = cnt_q;
    dq_d = dq_q; dr_d = dr_q; dd_d = dd_q; qneg_d = qneg_q; rneg_d = rneg_q;
    pbase_d = pbase_q; pacc_d = pacc_q; pexp_d = pexp_q; pphase_d = pphase_q;
    pbase_ovf_d = pbase_ovf_q; mul_fresh_d = mul_fresh_q;

    if (cmd_i.decode) begin
      res_d = '0;
      st_d  = cia_pkg::ST_OK;
      cnt_d = '0;
      my_d = mag(b_q); mp_d = '0;
      mxs_d = (2*DW)'(mag(a_q));
      mneg_d = a_q[DW-1] ^ b_q[DW-1];
      dq_d = mag(a_q); dr_d = '0; dd_d = mag(b_q);
      qneg_d = a_q[DW-1] ^ b_q[DW-1]; rneg_d = a_q[DW-1];
      pbase_d = a_q; pacc_d = DW'(1); pexp_d = b_q; pphase_d = 1'b0;
      pbase_ovf_d = 1'b0; mul_fresh_d = 1'b1;
      case (cia_pkg::op_e'(op_q))
        cia_pkg::OP_ADD: if (add_ovf) st_d = cia_pkg::ST_OVF; else res_d = sx(sum);
        cia_pkg::OP_SUB: if (sub_ovf) st_d = cia_pkg::ST_OVF; else res_d = sx(diff);
        cia_pkg::OP_MUL: ;
        cia_pkg::OP_DIV, cia_pkg::OP_MOD: begin
          if (b_q == '0) st_d = cia_pkg::ST_DIVZ;
          else if (a_q == minv && b_q == '1) st_d = cia_pkg::ST_OVF;
        end
        cia_pkg::OP_POW: begin
          if (b_q[DW-1]) st_d = cia_pkg::ST_NEGEX;
          else if (b_q == '0) res_d = 64'd1;
          else if (a_q == '0 || a_q == DW'(1)) res_d = sx(a_q);
          else if (a_q == '1) res_d = b_q[0] ? '1 : 64'd1;
          else if (b_q >= DW'(DW)) st_d = cia_pkg::ST_OVF;
        end
        cia_pkg::OP_NEG: if (a_q == minv) st_d = cia_pkg::ST_OVF; else res_d = sx(neg_a);
        cia_pkg::OP_CMP: begin
          if ($signed(a_q) > $signed(b_q)) res_d = 64'd1;
          else if ($signed(a_q) < $signed(b_q)) res_d = '1;
          else res_d = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.mul_step) begin
      mp_d  = mp_next;
      mxs_d = mxs_q << 1;
      my_d  = my_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (mul_ovf && st_q == cia_pkg::ST_OK) st_d = cia_pkg::ST_OVF;
      if (sts_o.iter_last && st_q == cia_pkg::ST_OK && !mul_ovf) res_d = sx(mul_res);
      if (st_d != cia_pkg::ST_OK) res_d = '0;
    end

    if (cmd_i.div_step) begin
      dr_d  = dfit ? dr_sh - {1'b0, dd_q} : dr_sh;
      dq_d  = {dq_q[DW-2:0], dfit};
      cnt_d = cnt_q + 1'b1;
      if (sts_o.iter_last) begin
        if (op_q == cia_pkg::OP_DIV)
          res_d = sx(qneg_q ? ~{dq_q[DW-2:0], dfit} + 1'b1 : {dq_q[DW-2:0], dfit});
        else
          res_d = sx(rneg_q ? ~dr_d[DW-1:0] + 1'b1 : dr_d[DW-1:0]);
      end
    end

    // power: each step advances a serial multiply by one bit; a fresh multiply first loads its operands
    if (cmd_i.pow_step) begin
      if (mul_fresh_q) begin
        my_d = my_op; mneg_d = mneg_op;
        mp_d = '0; mxs_d = (2*DW)'(mx_op); cnt_d = '0;
        mul_fresh_d = 1'b0;
      end else begin
        mp_d  = mp_next;
        mxs_d = mxs_q << 1;
        my_d  = my_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          mul_fresh_d = 1'b1;
          if (!pphase_q) begin
            // acc *= base applies only for a set exponent bit
            if (pexp_q[0]) begin
              if (mul_ovf || pbase_ovf_q) st_d = cia_pkg::ST_OVF;
              else pacc_d = mul_res;
            end
            pexp_d = pexp_q >> 1;
            pphase_d = 1'b1;
            if (pexp_q >> 1 == '0) begin
              res_d = (st_d == cia_pkg::ST_OK) ? sx(pacc_d) : '0;
            end
          end else begin
            if (mul_ovf) pbase_ovf_d = 1'b1;
            pbase_d = mul_res;
            pphase_d = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    sts_o.need_mul = 1'b0;
    sts_o.need_div = 1'b0;
    sts_o.need_pow = 1'b0;
    case (cia_pkg::op_e'(op_q))
      cia_pkg::OP_MUL: sts_o.need_mul = 1'b1;
      cia_pkg::OP_DIV, cia_pkg::OP_MOD:
        sts_o.need_div = !(b_q == '0) && !(a_q == minv && b_q == '1);
      cia_pkg::OP_POW:
        sts_o.need_pow = !b_q[DW-1] && b_q != '0 && a_q != '0 && a_q != DW'(1) &&
                         a_q != '1 && b_q < DW'(DW);
      default: ;
    endcase
    if (cmd_i.pow_step || pphase_q || !mul_fresh_q)
      sts_o.iter_last = !mul_fresh_q && cnt_q == LastBit && !pphase_q &&
                        (pexp_q >> 1) == '0;
    else
      sts_o.iter_last = cnt_q == LastBit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pphase_q <= 1'b0;
      mul_fresh_q <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      pphase_q <= pphase_d;
      mul_fresh_q <= mul_fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_i.req_type;
      a_q  <= a_in;
      b_q  <= b_in;
    end
    res_q <= res_d; st_q <= st_d;
    my_q <= my_d; mp_q <= mp_d; mxs_q <= mxs_d; mneg_q <= mneg_d;
    dq_q <= dq_d; dr_q <= dr_d; dd_q <= dd_d; qneg_q <= qneg_d; rneg_q <= rneg_d;
    pbase_q <= pbase_d; pacc_q <= pacc_d; pexp_q <= pexp_d;
    pbase_ovf_q <= pbase_ovf_d;
  end

  assign rsp_o.result_value = res_q;
  assign rsp_o.status       = st_q;

endmodule

>>> hw/rtl/cia_ctrl.sv
// ----------------------------------------------------------------------------
// cia_ctrl: sequencer for the checked ALU
// Loads a request, runs the chosen iterative unit if any, holds the response.
// ----------------------------------------------------------------------------
module cia_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  input  cia_pkg::sts_t sts_i,
  output cia_pkg::cmd_t cmd_o
);

  cia_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= cia_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_stall_o = 1'b1;
    rsp_valid_o = 1'b0;
    case (state_q)
      cia_pkg::S_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cia_pkg::S_DECODE;
        end
      end
      cia_pkg::S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.need_mul)      state_d = cia_pkg::S_MUL;
        else if (sts_i.need_div) state_d = cia_pkg::S_DIV;
        else if (sts_i.need_pow) state_d = cia_pkg::S_POW;
        else                     state_d = cia_pkg::S_DONE;
      end
      cia_pkg::S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.iter_last) state_d = cia_pkg::S_DONE;
      end
      cia_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.iter_last) state_d = cia_pkg::S_DONE;
      end
      cia_pkg::S_POW: begin
        cmd_o.pow_step = 1'b1;
        if (sts_i.iter_last) state_d = cia_pkg::S_DONE;
      end
      cia_pkg::S_DONE: begin
        rsp_valid_o = 1'b1;
        // accept the next item as the response leaves
        if (!rsp_stall_i) begin
          req_stall_o = 1'b0;
          if (req_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = cia_pkg::S_DECODE;
          end else begin
            state_d = cia_pkg::S_IDLE;
          end
        end
      end
      default: state_d = cia_pkg::S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/checked_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// checked_integer_alu_unit: 64-bit signed ALU with overflow/error status
// Controller plus bit-serial multiply/divide datapath.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid_i/req_stall_o| cia_pkg::req_t
//  rsp     | out       | rsp_valid_o/rsp_stall_i| cia_pkg::rsp_t
//
// Sequence from the accepting edge until the response is valid:
// add, sub, negate, compare, power special cases and error cases: decode,
// then response. Multiply, divide, modulus: decode, one bit per cycle, response.
// Power: 2*n - 1 serial multiplies, n the bit length of the exponent
// (at most 6 for 64 bits); each serial multiply starts with a setup step.
// The next item is taken in the cycle the response leaves; rsp_stall_i holds
// the response and stalls the input. Reset clears the sequencer and counters.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  cia_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output cia_pkg::rsp_t rsp_o
);

  cia_pkg::cmd_t cmd;
  cia_pkg::sts_t sts;

  cia_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .rsp_valid_o, .rsp_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  cia_datapath #(.DW(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

endmodule

>>> hw/rtl/cia_checker.sv
// ----------------------------------------------------------------------------
// cia_checker: port-level checks for the checked ALU
// Handshake and response-code sanity.
// ----------------------------------------------------------------------------
module cia_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_stall_o,
  input logic          rsp_valid_o,
  input logic          rsp_stall_i,
  input cia_pkg::rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != cia_pkg::ST_OK |-> rsp_o.result_value == '0)
    else $error("error response with nonzero value");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |-> req_stall_o)
    else $error("request taken while response blocked");

  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> !rsp_valid_o)
    else $error("response too early after request");

endmodule

bind checked_integer_alu_unit cia_checker u_cia_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .rsp_valid_o, .rsp_stall_i, .rsp_o
);
